// ===== src/tcdc_pkg.sv =====
// Package for the tube clock display controller: request and result payload types,
// sequencer state type, fixed constants and the packed-BCD increment helper.
// Depends on nothing; every source file of the block imports it.
package tcdc_pkg;

    localparam int TUBE_COUNT = 6;
    localparam int FRAME_W    = 60;

    localparam logic [15:0] C_US_PER_MS     = 16'd1000;
    localparam logic [10:0] C_MS_MAX        = 11'd2047;
    localparam logic [10:0] C_LIM_RESET     = 11'd1050;
    localparam logic [7:0]  C_SEC_RESET     = 8'd60;
    localparam logic [7:0]  C_BCD_SIXTY     = 8'h60;
    localparam logic [3:0]  C_BCD_DIGIT_TOP = 4'hA;
    localparam logic [3:0]  C_DIGIT_MAX     = 4'd9;
    localparam logic [6:0]  C_CENTI_CAP     = 7'd99;
    localparam logic [10:0] C_CENTI_KNEE    = 11'd990;
    localparam logic [7:0]  C_RECIP10       = 8'd205;
    localparam logic [2:0]  C_BRIGHT_MIN    = 3'd1;
    localparam logic [2:0]  C_BRIGHT_MAX    = 3'd5;
    localparam logic [3:0]  C_PWM_LAST      = 4'd9;

    typedef struct packed {
        logic [15:0] elapsed_us;
        logic [7:0]  clock_seconds;
        logic [7:0]  clock_minutes;
        logic [7:0]  clock_hours;
        logic        reset_button_pressed;
        logic        cycle_button_pressed;
        logic        bright_button_pressed;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0] cathode_frame;
        logic               display_lit;
        logic               clock_clear_request;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_UPDATE,
        ST_BUTTON,
        ST_CENTI,
        ST_DIGITS,
        ST_FRAME
    } t_state;

    // Packed-BCD increment on eight bits; a low digit that reaches ten carries up.
    function automatic logic [7:0] f_bcd_inc(input logic [7:0] v);
        logic [7:0] t;
        t = v + 8'd1;
        if (t[3:0] == C_BCD_DIGIT_TOP) begin
            t = {t[7:4] + 4'd1, 4'd0};
        end
        return t;
    endfunction

endpackage

// ===== src/tube_clock_display_controller.sv =====
// Top level of the tube clock display controller: timekeeping fallback, button
// debounce, mode and brightness control, and cathode frame generation.
// Depends on tcdc_pkg.

// Each request is one pass of the display loop and yields exactly one result.
// A request is taken only while o_in_stall is low, and the block then works
// on it step by step. Its elapsed time is added to the microsecond
// accumulator as it is taken, and the whole milliseconds in it (0 to 65) are
// drained: a single 16-bit compare-and-subtract unit removes one 1000 us step
// per cycle, the drain step then sees that the drain is done, and five
// sequencer steps handle the seconds check and fallback advance, the buttons,
// the two multiply-by-reciprocal divisions that give centiseconds and their
// digits, and the frame. The next request is accepted once the sequencer
// has written the result and gone back to idle. The result
// sits in an output register until it is taken, so the next request can be
// accepted while it waits; the sequencer only holds in its last step if a new
// result is ready while the old one is still stalled.
// The fallback limit register may be written at any time the block is idle.
module tube_clock_display_controller
    import tcdc_pkg::*;
#(
    parameter int DEBOUNCE_READS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data
);

    // Sequencer state.
    t_state r_state, n_state;

    // Configuration.
    logic [10:0] r_lim;

    // Persistent timekeeping state.
    logic [15:0] r_acc, n_acc;
    logic [10:0] r_ms, n_ms;
    logic [7:0]  r_prev, n_prev;

    // Button debounce state: one shift history and one latch per button.
    logic [2:0][DEBOUNCE_READS-1:0] r_hist, n_hist;
    logic [2:0]                     r_latch, n_latch;

    // Display modes. Brightness is kept as level / 20, so 1..5.
    logic        r_cyc_mode, n_cyc_mode;
    logic [3:0]  r_cyc_digit, n_cyc_digit;
    logic [7:0]  r_cyc_seen, n_cyc_seen;
    logic [2:0]  r_bright, n_bright;
    logic [3:0]  r_phase, n_phase;

    // Per-request working registers.
    t_in_item    r_in, n_in;
    logic [7:0]  r_sec, n_sec;
    logic [7:0]  r_min, n_min;
    logic        r_clear, n_clear;
    logic        r_lit, n_lit;
    logic [6:0]  r_centi, n_centi;
    logic [3:0]  r_tens, n_tens;

    // Output register.
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        w_in_take;
    logic        w_out_take;
    logic        w_out_free;
    logic        w_acc_ge;
    logic [18:0] w_centi_prod;
    logic [14:0] w_tens_prod;

    assign w_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_acc_ge   = (r_acc >= C_US_PER_MS);

    // Division by ten as multiplication by 205 / 2048; exact below 1029.
    assign w_centi_prod = 19'(r_ms) * 19'(C_RECIP10);
    assign w_tens_prod  = 15'(r_centi) * 15'(C_RECIP10);

    // One lit cathode for a tube, or nothing when the tube does not exist
    // or the digit is not a decimal digit.
    function automatic logic [FRAME_W-1:0] f_tube_bits(input int tube,
                                                       input logic [3:0] digit);
        logic [FRAME_W-1:0] bits;
        bits = '0;
        if (tube < TUBE_COUNT && digit <= C_DIGIT_MAX) begin
            bits[tube*10 + int'(digit)] = 1'b1;
        end
        return bits;
    endfunction

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (!w_acc_ge) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_BUTTON;
            ST_BUTTON: n_state = ST_CENTI;
            ST_CENTI:  n_state = ST_DIGITS;
            ST_DIGITS: n_state = ST_FRAME;
            ST_FRAME: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath driven by the sequencer.
    always_comb begin
        logic [10:0]        v_ms;
        logic [15:0]        v_acc;
        logic [7:0]         v_prev;
        logic [7:0]         v_sec;
        logic [7:0]         v_min;
        logic [2:0]         v_event;
        logic [6:0]         v_ones;
        logic [FRAME_W-1:0] v_frame;

        n_acc       = r_acc;
        n_ms        = r_ms;
        n_prev      = r_prev;
        n_hist      = r_hist;
        n_latch     = r_latch;
        n_cyc_mode  = r_cyc_mode;
        n_cyc_digit = r_cyc_digit;
        n_cyc_seen  = r_cyc_seen;
        n_bright    = r_bright;
        n_phase     = r_phase;
        n_in        = r_in;
        n_sec       = r_sec;
        n_min       = r_min;
        n_clear     = r_clear;
        n_lit       = r_lit;
        n_centi     = r_centi;
        n_tens      = r_tens;
        n_out_valid = r_out_valid && !w_out_take;
        n_out       = r_out;

        v_ms    = r_ms;
        v_acc   = r_acc;
        v_prev  = r_prev;
        v_sec   = r_sec;
        v_min   = r_min;
        v_event = '0;
        v_ones  = '0;
        v_frame = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_in  = i_in_data;
                    n_acc = r_acc + i_in_data.elapsed_us;
                end
            end

            ST_ACCUM: begin
                // One millisecond per cycle; the count saturates.
                if (w_acc_ge) begin
                    n_acc = r_acc - C_US_PER_MS;
                    if (r_ms != C_MS_MAX) begin
                        n_ms = r_ms + 11'd1;
                    end
                end
            end

            ST_UPDATE: begin
                v_sec = r_in.clock_seconds;
                v_min = r_in.clock_minutes;
                // A new second from the clock restarts the millisecond count.
                if (v_sec != v_prev) begin
                    v_ms   = '0;
                    v_acc  = '0;
                    v_prev = v_sec;
                end
                // The clock has gone quiet for too long: advance time locally.
                if (v_ms >= r_lim) begin
                    v_ms  = '0;
                    v_acc = '0;
                    v_sec = f_bcd_inc(v_sec);
                    if (v_sec >= C_BCD_SIXTY) begin
                        v_sec = '0;
                        v_min = f_bcd_inc(v_min);
                        if (v_min >= C_BCD_SIXTY) begin
                            v_min = '0;
                        end
                    end
                    v_prev = v_sec;
                end
                n_ms   = v_ms;
                n_acc  = v_acc;
                n_prev = v_prev;
                n_sec  = v_sec;
                n_min  = v_min;
            end

            ST_BUTTON: begin
                n_hist[0] = {r_hist[0][DEBOUNCE_READS-2:0], r_in.reset_button_pressed};
                n_hist[1] = {r_hist[1][DEBOUNCE_READS-2:0], r_in.cycle_button_pressed};
                n_hist[2] = {r_hist[2][DEBOUNCE_READS-2:0], r_in.bright_button_pressed};
                for (int k = 0; k < 3; k++) begin
                    if (n_hist[k] == '0) begin
                        n_latch[k] = 1'b0;
                    end
                    v_event[k] = (&n_hist[k]) && !n_latch[k];
                    if (v_event[k]) begin
                        n_latch[k] = 1'b1;
                    end
                end

                n_clear = v_event[0];
                if (v_event[0]) begin
                    v_sec  = '0;
                    v_min  = '0;
                    n_ms   = '0;
                    n_acc  = '0;
                    n_prev = '0;
                end
                n_sec = v_sec;
                n_min = v_min;

                if (v_event[1]) begin
                    n_cyc_mode = !r_cyc_mode;
                    if (!r_cyc_mode) begin
                        n_cyc_seen  = v_sec;
                        n_cyc_digit = '0;
                    end
                end
                if (v_event[2]) begin
                    n_bright = (r_bright == C_BRIGHT_MAX) ? C_BRIGHT_MIN : r_bright + 3'd1;
                end

                // The cycling digit steps once per change of the shown seconds.
                if (n_cyc_mode && (v_sec != n_cyc_seen)) begin
                    n_cyc_seen  = v_sec;
                    n_cyc_digit = (n_cyc_digit == C_DIGIT_MAX) ? 4'd0 : n_cyc_digit + 4'd1;
                end

                n_phase = (r_phase == C_PWM_LAST) ? 4'd0 : r_phase + 4'd1;
                n_lit   = n_phase < {n_bright, 1'b0};
            end

            ST_CENTI: begin
                n_centi = (r_ms >= C_CENTI_KNEE) ? C_CENTI_CAP : w_centi_prod[17:11];
            end

            ST_DIGITS: begin
                n_tens = w_tens_prod[14:11];
            end

            ST_FRAME: begin
                v_ones = r_centi - ({r_tens, 3'd0} + {2'd0, r_tens, 1'b0});
                if (r_cyc_mode) begin
                    for (int t = 0; t < 6; t++) begin
                        v_frame = v_frame | f_tube_bits(t, r_cyc_digit);
                    end
                end else begin
                    v_frame = f_tube_bits(5, r_min[7:4]) | f_tube_bits(4, r_min[3:0])
                            | f_tube_bits(3, r_sec[7:4]) | f_tube_bits(2, r_sec[3:0])
                            | f_tube_bits(1, r_tens)     | f_tube_bits(0, v_ones[3:0]);
                end
                if (w_out_free) begin
                    n_out_valid                   = 1'b1;
                    n_out.cathode_frame           = r_lit ? v_frame : '0;
                    n_out.display_lit             = r_lit;
                    n_out.clock_clear_request     = r_clear;
                end
            end

            default: begin
                n_out_valid = r_out_valid && !w_out_take;
            end
        endcase
    end

    // Port outputs.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    // Control and persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lim       <= C_LIM_RESET;
            r_acc       <= '0;
            r_ms        <= '0;
            r_prev      <= C_SEC_RESET;
            r_hist      <= '0;
            r_latch     <= '0;
            r_cyc_mode  <= 1'b0;
            r_cyc_digit <= '0;
            r_cyc_seen  <= C_SEC_RESET;
            r_bright    <= C_BRIGHT_MAX;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
            r_acc       <= n_acc;
            r_ms        <= n_ms;
            r_prev      <= n_prev;
            r_hist      <= n_hist;
            r_latch     <= n_latch;
            r_cyc_mode  <= n_cyc_mode;
            r_cyc_digit <= n_cyc_digit;
            r_cyc_seen  <= n_cyc_seen;
            r_bright    <= n_bright;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_clear <= n_clear;
        r_lit   <= n_lit;
        r_centi <= n_centi;
        r_tens  <= n_tens;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    // A result appears only as the sequencer leaves its last step.
    a_result_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FRAME)
        else $error("result raised outside the frame step");

    // A blanked pass carries no lit cathode.
    a_blank_is_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.display_lit) |-> (o_out_data.cathode_frame == '0))
        else $error("blanked result has cathodes set");

    // An accepted request always starts the millisecond drain.
    a_take_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_ACCUM))
        else $error("accepted request did not start processing");

    // Brightness level and PWM phase stay in their ranges.
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bright >= C_BRIGHT_MIN) && (r_bright <= C_BRIGHT_MAX) && (r_phase <= C_PWM_LAST))
        else $error("brightness or PWM phase out of range");

    // Leaving the drain means the accumulator holds less than one millisecond.
    a_drain_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> (r_acc < C_US_PER_MS))
        else $error("millisecond drain ended early");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for tube_clock_display_controller: directed and random display passes
// are checked against a scoreboard class that models the loop pass by pass.
// Depends on tcdc_pkg and the block's top level.
module tb;
    import tcdc_pkg::*;

    localparam int DB_READS         = 8;
    localparam int NUM_PHASES       = 10;
    localparam int PASSES_PER_PHASE = 165;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_TAIL       = 100;

    // Keeps its own copy of the controller state and predicts the frame of every
    // accepted pass; frames coming out of the block are compared in order.
    class frame_scoreboard;
        logic [10:0]         fallback_ms;
        logic [15:0]         us_acc;
        logic [10:0]         ms_count;
        logic [7:0]          prev_sec;
        logic [DB_READS-1:0] btn_hist [3];
        logic                btn_held [3];
        logic                cyc_mode;
        logic [3:0]          cyc_digit;
        logic [7:0]          cyc_sec_seen;
        logic [6:0]          bright;
        logic [3:0]          pwm_phase;
        t_out_item           expected_frames [$];
        int                  failures;

        function new();
            fallback_ms  = 11'd1050;
            us_acc       = '0;
            ms_count     = '0;
            prev_sec     = 8'd60;
            for (int k = 0; k < 3; k++) begin
                btn_hist[k] = '0;
                btn_held[k] = 1'b0;
            end
            cyc_mode     = 1'b0;
            cyc_digit    = '0;
            cyc_sec_seen = 8'd60;
            bright       = 7'd100;
            pwm_phase    = '0;
            failures     = 0;
        endfunction

        function logic [7:0] bcd_step(logic [7:0] v);
            logic [7:0] t;
            t = v + 8'd1;
            // A low digit that rolls over to ten carries into the high digit.
            if (t[3:0] == 4'hA) t = t + 8'd6;
            return t;
        endfunction

        function logic [59:0] cathode(int tube, int digit);
            if (tube >= TUBE_COUNT || digit > 9) return '0;
            return 60'd1 << (tube * 10 + digit);
        endfunction

        function t_out_item predict_pass(t_in_item p);
            t_out_item           res;
            logic [7:0]          secs;
            logic [7:0]          mins;
            logic [DB_READS-1:0] all_ones;
            logic [2:0]          levels;
            logic [2:0]          fired;
            logic [59:0]         frame;
            int                  centi;
            all_ones = '1;
            secs     = p.clock_seconds;
            mins     = p.clock_minutes;
            levels   = {p.bright_button_pressed, p.cycle_button_pressed,
                        p.reset_button_pressed};
            frame    = '0;

            us_acc = us_acc + p.elapsed_us;
            while (us_acc >= 16'd1000) begin
                us_acc = us_acc - 16'd1000;
                if (ms_count != 11'h7FF) ms_count = ms_count + 11'd1;
            end
            if (secs != prev_sec) begin
                ms_count = '0;
                us_acc   = '0;
                prev_sec = secs;
            end
            // Clock seems stopped: advance the shown time by one second locally.
            if (ms_count >= fallback_ms) begin
                ms_count = '0;
                us_acc   = '0;
                secs     = bcd_step(secs);
                if (secs >= 8'h60) begin
                    secs = '0;
                    mins = bcd_step(mins);
                    if (mins >= 8'h60) mins = '0;
                end
                prev_sec = secs;
            end
            centi = ms_count / 10;
            if (centi > 99) centi = 99;

            for (int k = 0; k < 3; k++) begin
                btn_hist[k] = {btn_hist[k][DB_READS-2:0], levels[k]};
                if (btn_hist[k] == '0) btn_held[k] = 1'b0;
                fired[k] = (btn_hist[k] == all_ones) && !btn_held[k];
                if (fired[k]) btn_held[k] = 1'b1;
            end
            if (fired[0]) begin
                ms_count = '0;
                centi    = 0;
                us_acc   = '0;
                secs     = '0;
                mins     = '0;
                prev_sec = '0;
            end
            if (fired[1]) begin
                cyc_mode = !cyc_mode;
                if (cyc_mode) begin
                    cyc_sec_seen = secs;
                    cyc_digit    = '0;
                end
            end
            if (fired[2]) begin
                bright = bright + 7'd20;
                if (bright > 7'd100) bright = 7'd20;
            end

            if (cyc_mode) begin
                if (secs != cyc_sec_seen) begin
                    cyc_sec_seen = secs;
                    cyc_digit    = (cyc_digit == 4'd9) ? 4'd0 : cyc_digit + 4'd1;
                end
                for (int t = 0; t < 6; t++) frame |= cathode(t, cyc_digit);
            end else begin
                frame |= cathode(5, mins[7:4]);
                frame |= cathode(4, mins[3:0]);
                frame |= cathode(3, secs[7:4]);
                frame |= cathode(2, secs[3:0]);
                frame |= cathode(1, centi / 10);
                frame |= cathode(0, centi % 10);
            end

            pwm_phase = (pwm_phase == 4'd9) ? 4'd0 : pwm_phase + 4'd1;
            res.display_lit         = (pwm_phase < bright / 10);
            res.cathode_frame       = res.display_lit ? frame : '0;
            res.clock_clear_request = fired[0];
            return res;
        endfunction

        function void note_pass(t_in_item p);
            expected_frames.push_back(predict_pass(p));
        endfunction

        function void check_frame(t_out_item got);
            t_out_item want;
            if (expected_frames.size() == 0) begin
                $display("%0t: result with no request waiting: frame=%h lit=%b clear=%b",
                         $time, got.cathode_frame, got.display_lit, got.clock_clear_request);
                failures++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.cathode_frame !== want.cathode_frame) begin
                $display("%0t: cathode_frame expected %h actual %h",
                         $time, want.cathode_frame, got.cathode_frame);
                failures++;
            end
            if (got.display_lit !== want.display_lit) begin
                $display("%0t: display_lit expected %b actual %b",
                         $time, want.display_lit, got.display_lit);
                failures++;
            end
            if (got.clock_clear_request !== want.clock_clear_request) begin
                $display("%0t: clock_clear_request expected %b actual %b",
                         $time, want.clock_clear_request, got.clock_clear_request);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_data  = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;
    bit          quiet       = 1'b0;
    int          idle_cycles = 0;

    frame_scoreboard sb = new();

    tube_clock_display_controller #(
        .DEBOUNCE_READS(DB_READS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random except during the quiet stretch.
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end

    // Both handshakes are sampled with the values that stood at the edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_pass(in_data);
        if (rst_n && out_valid && !out_stall) sb.check_frame(out_data);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item mk_pass(input logic [15:0] us, input logic [7:0] s,
                                         input logic [7:0] m, input logic [7:0] h,
                                         input logic [2:0] btn);
        t_in_item p;
        p.elapsed_us            = us;
        p.clock_seconds         = s;
        p.clock_minutes         = m;
        p.clock_hours           = h;
        p.reset_button_pressed  = btn[2];
        p.cycle_button_pressed  = btn[1];
        p.bright_button_pressed = btn[0];
        return p;
    endfunction

    // Offers one request, with a random gap in front of it, and returns once it is taken.
    task automatic push_pass(input t_in_item p);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // One edge passes first so that the request taken at the current edge is
    // already in the scoreboard before the queue is looked at.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_frames.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [10:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.fallback_ms = v;
    endtask

    initial begin : stimulus
        t_in_item    p;
        logic [7:0]  sim_sec;
        logic [7:0]  sim_min;
        logic [2:0]  lv;
        logic [10:0] lim [NUM_PHASES];
        int          hold [3];
        int          r;
        int          shift_top;
        bit          ticking;
        sim_sec = 8'h00;
        sim_min = 8'h00;
        hold    = '{0, 0, 0};
        lim     = '{11'd1050, 11'd1, 11'd2000, 11'd2047, 11'd0,
                    11'd7, 11'd0, 11'd0, 11'd300, 11'd1050};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Highest limit: accumulator extremes, its 16-bit wrap, and non-BCD time.
        write_limit(11'd2047);
        push_pass(mk_pass(16'd0,     8'h00, 8'h00, 8'h00, 3'b000));
        push_pass(mk_pass(16'hFFFF,  8'h00, 8'h00, 8'h00, 3'b000));
        push_pass(mk_pass(16'hFFFF,  8'h00, 8'h00, 8'h00, 3'b000));
        push_pass(mk_pass(16'hFFFF,  8'h00, 8'h59, 8'h23, 3'b000));
        push_pass(mk_pass(16'd12345, 8'hFF, 8'hFF, 8'hFF, 3'b000));
        push_pass(mk_pass(16'd999,   8'hFF, 8'hFF, 8'hFF, 3'b000));
        push_pass(mk_pass(16'd1,     8'hFF, 8'hFF, 8'hFF, 3'b000));

        // Limit lowered to zero below the running count: every pass advances time,
        // including the minute wrap and a non-BCD low digit.
        wait_drained();
        write_limit(11'd0);
        push_pass(mk_pass(16'd0, 8'h59, 8'h59, 8'h23, 3'b000));
        push_pass(mk_pass(16'd0, 8'h59, 8'h59, 8'h23, 3'b000));
        push_pass(mk_pass(16'd0, 8'h5A, 8'h3F, 8'h00, 3'b000));
        push_pass(mk_pass(16'd0, 8'h09, 8'hA0, 8'h99, 3'b000));
        // All three buttons held long enough to act on the same pass.
        for (int i = 0; i < DB_READS; i++) begin
            push_pass(mk_pass(16'd700, 8'h33, 8'h12, 8'h07, 3'b111));
        end
        for (int i = 0; i < 3; i++) begin
            push_pass(mk_pass(16'd5000, 8'h34, 8'h12, 8'h07, 3'b000));
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if (ph == 6 || ph == 7) lim[ph] = 11'($urandom_range(0, 2047));
            write_limit(lim[ph]);
            quiet     = (ph == 2 || ph == 3);
            // Odd phases have a ticking clock; even ones leave time to the fallback.
            ticking   = (ph % 2 == 1);
            shift_top = (lim[ph] > 500) ? 3 : 10;
            for (int n = 0; n < PASSES_PER_PHASE; n++) begin
                // Hold off the next request until every frame so far has come back.
                if (ph == 1 && n == PASSES_PER_PHASE / 2) wait_drained();

                r = $urandom_range(0, 99);
                if (r < 3) p.elapsed_us = 16'hFFFF;
                else if (r < 5) p.elapsed_us = 16'd0;
                else if (r < 10) p.elapsed_us = 16'($urandom_range(0, 65535));
                else p.elapsed_us = 16'($urandom_range(0, 65535) >> $urandom_range(0, shift_top));

                r = $urandom_range(0, 99);
                if (ticking && r < 6) begin
                    sim_sec = sb.bcd_step(sim_sec);
                    if (sim_sec >= 8'h60) begin
                        sim_sec = 8'h00;
                        sim_min = sb.bcd_step(sim_min);
                        if (sim_min >= 8'h60) sim_min = 8'h00;
                    end
                end
                p.clock_seconds = (r >= 97) ? 8'($urandom_range(0, 255)) : sim_sec;
                p.clock_minutes = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(0, 255))
                                                              : sim_min;
                p.clock_hours   = 8'($urandom_range(0, 255));

                // Presses of random length, some too short to count, plus glitches.
                for (int k = 0; k < 3; k++) begin
                    if (hold[k] > 0) begin
                        lv[k] = 1'b1;
                        hold[k]--;
                    end else if ($urandom_range(0, 99) < 2) begin
                        lv[k] = 1'b1;
                        hold[k] = $urandom_range(2, 20);
                    end else begin
                        lv[k] = 1'b0;
                    end
                    if ($urandom_range(0, 99) < 2) lv[k] = !lv[k];
                end
                p.reset_button_pressed  = lv[0];
                p.cycle_button_pressed  = lv[1];
                p.bright_button_pressed = lv[2];
                push_pass(p);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (sb.failures == 0 && sb.expected_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
